// ----- rtl/core/ttip_pkg.sv -----
// Shared types, constants and helpers for the streaming text-to-integer parser.
// No dependencies; every other file of the block uses this package.
package ttip_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned BaseW    = 6;
  localparam int unsigned PosW     = 16;
  localparam int unsigned ValW     = 64;
  localparam int unsigned ProdW    = ValW + BaseW + 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Offset counter stops here (text length limit and field width agree)
  localparam logic [PosW-1:0] PosCap = 16'hFFFF;

  localparam logic [BaseW-1:0] BaseAuto = 6'd0;
  localparam logic [BaseW-1:0] Base8    = 6'd8;
  localparam logic [BaseW-1:0] Base10   = 6'd10;
  localparam logic [BaseW-1:0] Base16   = 6'd16;

  // Character codes
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChUpX   = 8'h58;
  localparam logic [ChW-1:0] ChLowX  = 8'h78;

  // Signed limits; the negative ones are magnitudes
  localparam logic [ValW-1:0] Lim32Pos = 64'h0000_0000_7FFF_FFFF;
  localparam logic [ValW-1:0] Lim32Neg = 64'h0000_0000_8000_0000;
  localparam logic [ValW-1:0] Lim64Pos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] Lim64Neg = 64'h8000_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE   = 2'd0,
    CFG_SIGNED = 2'd1,
    CFG_WIDE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [BaseW-1:0] base_select;
    logic             signed_mode;
    logic             wide_mode;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [ValW-1:0]  acc;
    logic             neg;
    logic             ovf;
    logic             seen;
    logic [BaseW-1:0] base;
    logic [PosW-1:0]  pos;
  } parse_st_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [PosW-1:0] end_offset;
    logic            range_error;
    logic            found_digits;
  } result_t;

  typedef struct packed {
    logic             ok;
    logic [BaseW-1:0] val;
  } digit_t;

  // Map a character to its digit value (0-9, A-Z, a-z)
  function automatic digit_t digit_value(logic [ChW-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d.val = BaseW'(c - 8'h30);
    end else if (c inside {[8'h41:8'h5A]}) begin
      d.val = BaseW'(c - 8'h37);
    end else if (c inside {[8'h61:8'h7A]}) begin
      d.val = BaseW'(c - 8'h57);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/ttip_if.sv -----
// Valid/ready channel interfaces for the parser's character input and result output.
// Depends on ttip_pkg for field widths.
interface ttip_in_if;
  logic                     valid;
  logic                     ready;
  logic [ttip_pkg::ChW-1:0] ch;
  logic                     first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

interface ttip_out_if;
  logic                      valid;
  logic                      ready;
  logic [ttip_pkg::ValW-1:0] value;
  logic [ttip_pkg::PosW-1:0] end_offset;
  logic                      range_error;
  logic                      found_digits;

  modport source (output valid, output value, output end_offset, output range_error,
                  output found_digits, input ready);
  modport sink   (input valid, input value, input end_offset, input range_error,
                  input found_digits, output ready);
endinterface

// ----- rtl/core/ttip_cfg.sv -----
// Configuration register bank: base select, signed mode and wide mode.
// Depends on ttip_pkg.
module ttip_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttip_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ttip_pkg::cfg_t                cfg_o
);
  import ttip_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_select <= Base10;
      cfg_q.signed_mode <= 1'b1;
      cfg_q.wide_mode   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:   cfg_q.base_select <= cfg_wdata_i[BaseW-1:0];
        CFG_SIGNED: cfg_q.signed_mode <= cfg_wdata_i[0];
        CFG_WIDE:   cfg_q.wide_mode   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/ttip_step.sv -----
// Per-character parse step: next parser state, digit multiply-add with limit check,
// and the result word. Purely combinational; depends on ttip_pkg.
module ttip_step (
  input  ttip_pkg::parse_st_t         st_i,
  input  ttip_pkg::cfg_t              cfg_i,
  input  logic [ttip_pkg::ChW-1:0]    ch_i,
  input  logic                        first_i,
  output ttip_pkg::parse_st_t         st_o,
  output logic                        emit_o,
  output ttip_pkg::result_t           res_o
);
  import ttip_pkg::*;

  parse_st_t        st_d;
  phase_e           cur_phase;
  logic             active;
  logic             start;
  logic             to_digit;
  logic             is_space;
  digit_t           dig;
  logic [BaseW-1:0] mul_base;
  logic [ProdW-1:0] prod;
  logic [ValW-1:0]  lim;

  assign dig      = digit_value(ch_i);
  assign is_space = (ch_i == ChSpace) || (ch_i inside {[8'd9:8'd13]});

  always_comb begin
    st_d      = st_i;
    active    = 1'b1;
    start     = 1'b0;
    to_digit  = 1'b0;
    emit_o    = 1'b0;
    cur_phase = first_i ? PH_LEAD : st_i.phase;

    // Restart on a new string, drop characters while idle or finished
    if (first_i) begin
      st_d.pos   = '0;
      st_d.acc   = '0;
      st_d.neg   = 1'b0;
      st_d.ovf   = 1'b0;
      st_d.seen  = 1'b0;
      st_d.base  = cfg_i.base_select;
      st_d.phase = PH_LEAD;
    end else if (st_i.phase == PH_IDLE || st_i.phase == PH_DONE) begin
      active = 1'b0;
    end else if (st_i.pos < PosCap) begin
      st_d.pos = st_i.pos + PosW'(1);
    end

    // Leading part: white space, sign, zero and prefix
    if (active) begin
      case (cur_phase)
        PH_LEAD: begin
          if (is_space) begin
            st_d.phase = PH_LEAD;
          end else if (ch_i == ChMinus && cfg_i.signed_mode) begin
            st_d.neg   = 1'b1;
            st_d.phase = PH_SIGNED;
          end else if (ch_i == ChPlus) begin
            st_d.phase = PH_SIGNED;
          end else begin
            start = 1'b1;
          end
        end
        PH_SIGNED: start = 1'b1;
        PH_ZERO: begin
          if (ch_i == ChLowX || ch_i == ChUpX) begin
            st_d.base  = Base16;
            st_d.phase = PH_DIGITS;
          end else begin
            if (st_d.base == BaseAuto) st_d.base = Base8;
            // The leading zero counts as a digit; the value stays zero
            st_d.seen = 1'b1;
            to_digit  = 1'b1;
          end
        end
        PH_DIGITS: to_digit = 1'b1;
        default: ;
      endcase
    end

    // Number start: hold a leading zero when a prefix may follow
    if (start) begin
      if ((st_d.base == BaseAuto || st_d.base == Base16) && ch_i == ChZero) begin
        st_d.phase = PH_ZERO;
      end else begin
        if (st_d.base == BaseAuto) st_d.base = Base10;
        to_digit = 1'b1;
      end
    end

    // Multiply-add; the product against the limit replaces the cutoff test
    mul_base = (st_d.base == BaseAuto) ? Base10 : st_d.base;
    prod     = ProdW'(st_d.acc) * ProdW'(mul_base) + ProdW'(dig.val);
    if (cfg_i.wide_mode) lim = st_d.neg ? Lim64Neg : Lim64Pos;
    else                 lim = st_d.neg ? Lim32Neg : Lim32Pos;

    // Digit: accumulate, or end the number
    if (to_digit) begin
      st_d.phase = PH_DIGITS;
      if (dig.ok && dig.val < st_d.base) begin
        st_d.seen = 1'b1;
        if (cfg_i.signed_mode) begin
          if (st_d.ovf || prod > ProdW'(lim)) st_d.ovf = 1'b1;
          else                                 st_d.acc = prod[ValW-1:0];
        end else begin
          st_d.acc = prod[ValW-1:0];
        end
      end else begin
        emit_o     = 1'b1;
        st_d.phase = PH_DONE;
      end
    end
  end

  // Form the result word from the updated state
  always_comb begin
    res_o.value = '0;
    if (st_d.seen) begin
      if (cfg_i.signed_mode) begin
        if (st_d.ovf) res_o.value = st_d.neg ? (ValW'(0) - lim) : lim;
        else          res_o.value = st_d.neg ? (ValW'(0) - st_d.acc) : st_d.acc;
      end else begin
        res_o.value = st_d.acc;
      end
    end
    res_o.end_offset   = st_d.seen ? st_d.pos : '0;
    res_o.range_error  = st_d.seen && cfg_i.signed_mode && st_d.ovf;
    res_o.found_digits = st_d.seen;
  end

  assign st_o = st_d;

endmodule

// ----- rtl/core/text_to_integer_parser_core.sv -----
// Top level of the streaming text-to-integer parser: input register, parser state,
// result register. Depends on ttip_pkg, ttip_if, ttip_cfg and ttip_step.
//
// The parser takes one character word per cycle unless the result side stalls, and
// emits one result word on the character that ends a number (value, end offset,
// range and digit flags). The character is captured in the input register at its
// accepting edge, and the step logic loads the result register from it once the
// result register has room. The 64x6 multiply-add and limit compare in ttip_step
// lie in the same combinational path as the state update. Stalls on the result
// side back up into the input register and then the input channel.
// Configuration writes take effect on the next character that reaches the step logic.
module text_to_integer_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ttip_in_if.sink                       in_port,
  ttip_out_if.source                    out_port,
  input  logic                          cfg_we_i,
  input  logic [ttip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttip_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ttip_pkg::*;

  cfg_t            cfg;
  parse_st_t       st_q;
  parse_st_t       st_d;
  result_t         res_d;
  result_t         res_q;
  logic            emit;
  logic            in_valid_q;
  logic [ChW-1:0]  in_ch_q;
  logic            in_first_q;
  logic            out_valid_q;
  logic            advance;

  ttip_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ttip_step u_step (
    .st_i    (st_q),
    .cfg_i   (cfg),
    .ch_i    (in_ch_q),
    .first_i (in_first_q),
    .st_o    (st_d),
    .emit_o  (emit),
    .res_o   (res_d)
  );

  // Advance the held word when the result register has room
  assign advance       = in_valid_q && (!out_valid_q || out_port.ready);
  assign in_port.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_port.ready) begin
      in_valid_q <= in_port.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_port.ready && in_port.valid) begin
      in_ch_q    <= in_port.ch;
      in_first_q <= in_port.first;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase <= PH_IDLE;
      st_q.acc   <= '0;
      st_q.neg   <= 1'b0;
      st_q.ovf   <= 1'b0;
      st_q.seen  <= 1'b0;
      st_q.base  <= Base10;
      st_q.pos   <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_port.valid        = out_valid_q;
  assign out_port.value        = res_q.value;
  assign out_port.end_offset   = res_q.end_offset;
  assign out_port.range_error  = res_q.range_error;
  assign out_port.found_digits = res_q.found_digits;

  // A new result word only follows a word held in the input register
  a_result_from_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without an input word");

  // A string start always takes the parser out of idle
  a_start_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_first_q) |=> (st_q.phase != PH_IDLE))
    else $error("parser idle after string start");

  // No digits means an all-zero result
  a_no_digit_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.found_digits) |->
      (res_q.value == '0 && res_q.end_offset == '0 && !res_q.range_error))
    else $error("nonzero result without digits");

  // Saturation flag requires signed accumulation in progress
  a_ovf_signed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !st_q.ovf && st_d.ovf) |-> (cfg.signed_mode && st_d.seen))
    else $error("overflow flagged outside signed accumulation");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for text_to_integer_parser_core: streams character words,
// predicts every parse result and compares each result word field by field.
// Depends on ttip_pkg, ttip_in_if / ttip_out_if and the parser core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ttip_pkg::*;

  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 10;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PrintLimit   = 50;

  // White space range below the space character, and the NUL character
  localparam logic [ChW-1:0] ChTab = 8'd9;
  localparam logic [ChW-1:0] ChCr  = 8'd13;
  localparam logic [ChW-1:0] ChNul = 8'd0;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           first;
  } char_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ttip_in_if  in_if ();
  ttip_out_if out_if ();

  text_to_integer_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_port     (in_if),
    .out_port    (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers
  cfg_t       cfg_m;
  parse_st_t  ps;

  char_word_t char_q[$];
  result_t    expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned queued_items   = 0;
  int unsigned in_gap         = 0;
  int unsigned out_stall      = 0;
  int unsigned idle_cycles    = 0;
  bit          in_calm        = 1'b0;
  bit          out_calm       = 1'b0;
  bit          fresh          = 1'b0;
  char_word_t  next_word;
  result_t     predicted;
  result_t     want;

  logic [ValW-1:0] boundary_vals [5];

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] digit_of(logic [ChW-1:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
    if (c >= "a" && c <= "z") return c - "a" + 8'd10;
    return 8'hFF;
  endfunction

  function automatic logic [ValW-1:0] limit_of();
    if (cfg_m.wide_mode) return ps.neg ? Lim64Neg : Lim64Pos;
    return ps.neg ? Lim32Neg : Lim32Pos;
  endfunction

  // Accumulate one digit, saturating in signed mode
  function automatic void take_digit(logic [7:0] d);
    logic [ValW-1:0] b;
    logic [ValW-1:0] lim;
    logic [ValW-1:0] cut;
    logic [ValW-1:0] cut_rem;
    b = (ps.base != '0) ? ValW'(ps.base) : 64'd10;
    ps.seen = 1'b1;
    if (cfg_m.signed_mode) begin
      lim     = limit_of();
      cut     = lim / b;
      cut_rem = lim % b;
      if (ps.ovf || ps.acc > cut || (ps.acc == cut && ValW'(d) > cut_rem)) begin
        ps.ovf = 1'b1;
        return;
      end
    end
    ps.acc = ps.acc * b + ValW'(d);
  endfunction

  // Take a digit or end the number and build the result
  function automatic bit digit_step(logic [ChW-1:0] c, output result_t res);
    logic [7:0]      d;
    logic [ValW-1:0] lim;
    res      = '0;
    d        = digit_of(c);
    ps.phase = PH_DIGITS;
    if (d < 8'(ps.base)) begin
      take_digit(d);
      return 1'b0;
    end
    if (ps.seen) begin
      if (!cfg_m.signed_mode) begin
        res.value = ps.acc;
      end else if (ps.ovf) begin
        lim             = limit_of();
        res.value       = ps.neg ? -lim : lim;
        res.range_error = 1'b1;
      end else begin
        res.value = ps.neg ? -ps.acc : ps.acc;
      end
      res.end_offset   = ps.pos;
      res.found_digits = 1'b1;
    end
    ps.phase = PH_DONE;
    return 1'b1;
  endfunction

  // First character after white space and sign: may open a prefix
  function automatic bit start_number(logic [ChW-1:0] c, output result_t res);
    res = '0;
    if ((ps.base == BaseAuto || ps.base == Base16) && c == ChZero) begin
      ps.phase = PH_ZERO;
      return 1'b0;
    end
    if (ps.base == BaseAuto) ps.base = Base10;
    return digit_step(c, res);
  endfunction

  function automatic bit parse_char(logic [ChW-1:0] c, logic first, output result_t res);
    res = '0;
    if (first) begin
      ps.pos   = '0;
      ps.acc   = '0;
      ps.neg   = 1'b0;
      ps.ovf   = 1'b0;
      ps.seen  = 1'b0;
      ps.base  = cfg_m.base_select;
      ps.phase = PH_LEAD;
    end else begin
      if (ps.phase == PH_IDLE || ps.phase == PH_DONE) return 1'b0;
      if (ps.pos < PosCap) ps.pos = ps.pos + PosW'(1);
    end
    case (ps.phase)
      PH_LEAD: begin
        if (c == ChSpace || (c >= ChTab && c <= ChCr)) return 1'b0;
        if (c == ChMinus && cfg_m.signed_mode) begin
          ps.neg   = 1'b1;
          ps.phase = PH_SIGNED;
          return 1'b0;
        end
        if (c == ChPlus) begin
          ps.phase = PH_SIGNED;
          return 1'b0;
        end
        return start_number(c, res);
      end
      PH_SIGNED: return start_number(c, res);
      PH_ZERO: begin
        if (c == ChLowX || c == ChUpX) begin
          ps.base  = Base16;
          ps.phase = PH_DIGITS;
          return 1'b0;
        end
        if (ps.base == BaseAuto) ps.base = Base8;
        take_digit(8'd0);
        return digit_step(c, res);
      end
      default: return digit_step(c, res);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ChW-1:0] digit_sym(logic [7:0] d);
    if (d < 8'd10) return "0" + d;
    return ($urandom_range(0, 1) ? "a" : "A") + d - 8'd10;
  endfunction

  task automatic put_raw(logic [ChW-1:0] c, logic f);
    char_q.push_back({c, f});
    queued_items++;
  endtask

  // Append a word; the first one of a string carries the start flag
  task automatic put(logic [ChW-1:0] c);
    put_raw(c, fresh);
    fresh = 1'b0;
  endtask

  task automatic put_text(string s);
    fresh = 1'b1;
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_value(logic [ValW-1:0] v, int unsigned b);
    logic [7:0] digs[$];
    do begin
      digs.push_front(digit_sym(8'(v % b)));
      v = v / b;
    end while (v != 0);
    foreach (digs[i]) put(digs[i]);
  endtask

  // One string: white space, sign, prefix, digits, terminator, trailing junk
  task automatic gen_number();
    int unsigned b;
    int unsigned eff;
    int unsigned kind;
    fresh = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        put($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(ChTab, ChCr)));
    end
    case ($urandom_range(0, 3))
      0: put(ChMinus);
      1: put(ChPlus);
      default: ;
    endcase
    b   = cfg_m.base_select;
    eff = b;
    if ((b == BaseAuto || b == Base16) && $urandom_range(0, 2) == 0) begin
      put(ChZero);
      put($urandom_range(0, 1) ? ChLowX : ChUpX);
      eff = 16;
    end else if (b == BaseAuto) begin
      // leading zero selects octal
      eff = ($urandom_range(0, 2) == 0) ? 8 : 10;
      if (eff == 8) put(ChZero);
    end
    if (eff > 36) eff = 36;
    kind = $urandom_range(0, 11);
    if (eff <= 1) begin
      if (kind != 0) repeat ($urandom_range(1, 4)) put(ChZero);
    end else begin
      case (kind)
        0: ;
        1, 2, 3: put_value(ValW'($urandom_range(0, 99999)), eff);
        4, 5, 6: put_value(boundary_vals[$urandom_range(0, 4)] +
                           ValW'($urandom_range(0, 2)) - 64'd1, eff);
        7, 8: put_value({$urandom, $urandom}, eff);
        default: repeat ($urandom_range(1, 25)) put(digit_sym(8'($urandom_range(0, eff - 1))));
      endcase
    end
    case ($urandom_range(0, 7))
      0: put(ChNul);
      1: put(ChSpace);
      2: put(8'hFF);
      3: put(ChMinus);
      4: put(8'($urandom));
      5: ;
      default: put(",");
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_raw(8'($urandom), 1'b0);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4)) put_raw(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // Wait until every word is in and every result is out, then let the pipe empty
  task automatic wait_drained();
    @(negedge clk_i);
    while (char_q.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASE:   cfg_m.base_select = data;
      CFG_SIGNED: cfg_m.signed_mode = data[0];
      CFG_WIDE:   cfg_m.wide_mode   = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [BaseW-1:0] base, logic sgn, logic wide);
    write_reg(CFG_BASE, base);
    write_reg(CFG_SIGNED, CfgDataW'(sgn));
    write_reg(CFG_WIDE, CfgDataW'(wide));
  endtask

  task automatic report_mismatch(string what, logic [ValW-1:0] got, logic [ValW-1:0] exp_v);
    if (mismatch_count < PrintLimit)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, exp_v);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued words, predict on each accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        if (parse_char(in_if.ch, in_if.first, predicted)) expected_results.push_back(predicted);
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          next_word    = char_q.pop_front();
          in_if.ch    <= next_word.ch;
          in_if.first <= next_word.first;
          in_if.valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
          in_gap = pick_gap(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result words, stall the output at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_if.value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_if.value !== want.value)
            report_mismatch("value", out_if.value, want.value);
          if (out_if.end_offset !== want.end_offset)
            report_mismatch("end_offset", ValW'(out_if.end_offset), ValW'(want.end_offset));
          if (out_if.range_error !== want.range_error)
            report_mismatch("range_error", ValW'(out_if.range_error), ValW'(want.range_error));
          if (out_if.found_digits !== want.found_digits)
            report_mismatch("found_digits", ValW'(out_if.found_digits), ValW'(want.found_digits));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed strings, random phases
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned base_list [9];
    int unsigned start_count;
    logic [BaseW-1:0] base_pick;

    in_if.valid  = 1'b0;
    in_if.ch     = '0;
    in_if.first  = 1'b0;
    out_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_BASE;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;

    boundary_vals[0] = Lim32Pos;
    boundary_vals[1] = Lim32Neg;
    boundary_vals[2] = Lim64Pos;
    boundary_vals[3] = Lim64Neg;
    boundary_vals[4] = '1;
    base_list = '{0, 1, 2, 8, 10, 16, 36, 37, 63};

    cfg_m.base_select = Base10;
    cfg_m.signed_mode = 1'b1;
    cfg_m.wide_mode   = 1'b1;
    ps.phase = PH_IDLE;
    ps.acc   = '0;
    ps.neg   = 1'b0;
    ps.ovf   = 1'b0;
    ps.seen  = 1'b0;
    ps.base  = Base10;
    ps.pos   = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: ignored word while idle, sign, white space, restart
    put_raw("A", 1'b0);
    put_text("-12");
    put(ChNul);
    put_raw("7", 1'b0);
    put_text("\t+9");
    put(8'hFF);
    put_text("z");
    put_text("5");
    put_text("8");
    put(ChSpace);
    put_text("-5");
    wait_drained();

    // Automatic base, unsigned: mode change mid-string, empty prefix, minus, octal
    set_config(BaseAuto, 1'b0, 1'b1);
    put("3");
    put(ChNul);
    put_text("0xg");
    put_text("-1");
    put_text("077");
    put(ChNul);
    wait_drained();

    // Base one only takes zeros; 32-bit negative limit
    set_config(6'd1, 1'b1, 1'b0);
    put_text("001");
    wait_drained();
    set_config(Base10, 1'b1, 1'b0);
    put_text("-2147483649 ");
    wait_drained();

    // Random phases across base and mode settings
    start_count = queued_items;
    for (int ph = 0; queued_items - start_count < RandomItems; ph++) begin
      base_pick = (ph < 9) ? BaseW'(base_list[ph]) : BaseW'($urandom_range(0, 63));
      if (ph < 4) set_config(base_pick, ph[0], ph[1]);
      else set_config(base_pick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // continue an unfinished string from the previous phase
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) put_raw(8'("0" + $urandom_range(0, 9)), 1'b0);
        put_raw(ChNul, 1'b0);
      end
      repeat ($urandom_range(10, 20)) begin
        if ($urandom_range(0, 9) == 0) gen_noise();
        else gen_number();
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ttip_pkg.sv
rtl/core/ttip_if.sv
rtl/core/ttip_cfg.sv
rtl/core/ttip_step.sv
rtl/core/text_to_integer_parser_core.sv
tb/testbench.sv
